FILE: src/pot_pkg.sv
// ----------------------------------------------------------------------------
// Polygon orientation test package
// Shared widths, limits and types for the streamed shoelace orientation test.
// ----------------------------------------------------------------------------
package pot_pkg;

    // Default coordinate width and the fixed width of the area accumulator.
    localparam int COORD_BITS_DEF = 24;
    localparam int SUM_BITS       = 64;

    // Distinct-vertex counter saturates at four.
    localparam int          COUNT_BITS   = 3;
    localparam logic [2:0]  COUNT_ONE    = 3'd1;
    localparam logic [2:0]  COUNT_TWO    = 3'd2;
    localparam logic [2:0]  MAX_DISTINCT = 3'd4;

    // Saturation limits of the signed accumulator.
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
    localparam logic signed [SUM_BITS-1:0] SUM_ZERO = '0;

    // Control bits that travel with a vertex through the cross-product stage.
    typedef struct packed {
        logic first;    // first vertex of a polygon, clears the sum
        logic edge_en;  // vertex differs from the prior one, adds an edge
        logic fin;      // last vertex of the polygon, yields a result
        logic degen;    // fewer than three distinct vertices
    } stage_ctl_t;

endpackage

FILE: src/pot_cross.sv
// ----------------------------------------------------------------------------
// Polygon orientation cross product
// Computes ax*by - bx*ay for two signed fixed-point vertices.
// ----------------------------------------------------------------------------
module pot_cross
    import pot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    output logic signed [2*COORD_BITS:0] area_term
);

    localparam int PROD_BITS = 2 * COORD_BITS;

    logic signed [PROD_BITS-1:0] prod_ab;
    logic signed [PROD_BITS-1:0] prod_ba;

    // Two independent products, then one subtract with a guard bit.
    assign prod_ab   = ax * by;
    assign prod_ba   = bx * ay;
    assign area_term = {prod_ab[PROD_BITS-1], prod_ab} - {prod_ba[PROD_BITS-1], prod_ba};

endmodule

FILE: src/polygon_orientation_test.sv
// Path: a vertex accepted into the input register passes the cross-product and
// accumulator stages; a final vertex then loads its result into the output register.
// Throughput: one vertex per cycle while no stall holds the pipeline; the edge and
// closing cross products run in parallel multipliers and the accumulator adds one edge per cycle when not stalled.
// Reset: asynchronous, clears all stage valids, the polygon state and the sum.
// ----------------------------------------------------------------------------
// Polygon orientation test
// Streams polygon vertices, accumulates the shoelace sum with saturation and
// reports orientation and degeneracy on each final vertex.
// ----------------------------------------------------------------------------
module polygon_orientation_test
    import pot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] x_coord,
    input  logic signed [COORD_BITS-1:0] y_coord,
    input  logic                         final_vertex,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         clockwise,
    output logic                         degenerate
);

    localparam int CROSS_BITS = 2 * COORD_BITS + 1;

    // Input register.
    logic                         s0_valid_reg;
    logic signed [COORD_BITS-1:0] s0_x_reg;
    logic signed [COORD_BITS-1:0] s0_y_reg;
    logic                         s0_fin_reg;

    // Polygon state.
    logic                         within_reg;
    logic                         within_next;
    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] prior_x_reg;
    logic signed [COORD_BITS-1:0] prior_y_reg;
    logic signed [COORD_BITS-1:0] start_x_next;
    logic signed [COORD_BITS-1:0] start_y_next;
    logic signed [COORD_BITS-1:0] prior_x_next;
    logic signed [COORD_BITS-1:0] prior_y_next;
    logic [COUNT_BITS-1:0]        count_reg;
    logic [COUNT_BITS-1:0]        count_next;
    logic [COUNT_BITS-1:0]        count_fin;

    // Cross-product stage.
    logic                         s1_valid_reg;
    stage_ctl_t                   s1_ctl_reg;
    stage_ctl_t                   s1_ctl_next;
    logic signed [CROSS_BITS-1:0] s1_edge_reg;
    logic signed [CROSS_BITS-1:0] s1_close_reg;
    logic signed [CROSS_BITS-1:0] edge_cross;
    logic signed [CROSS_BITS-1:0] close_cross;

    // Accumulator stage.
    logic                         s2_valid_reg;
    logic                         s2_fin_reg;
    logic                         s2_degen_reg;
    logic signed [CROSS_BITS-1:0] s2_close_reg;
    logic signed [SUM_BITS-1:0]   sum_reg;
    logic signed [SUM_BITS-1:0]   sum_next;
    logic signed [SUM_BITS-1:0]   sum_base;
    logic signed [SUM_BITS:0]     sum_wide;

    // Output register.
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         clockwise_reg;
    logic                         degenerate_reg;
    logic signed [SUM_BITS:0]     total_wide;

    // Handshake chain.
    logic out_ready;
    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic s0_go;
    logic s0_free;
    logic in_take;

    logic first_vtx;
    logic differs;
    logic same_start;

    // Each stage moves when the next one is empty or moving; a non-final
    // vertex leaves the accumulator stage without needing the output register.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_go     = s2_valid_reg && (!s2_fin_reg || out_ready);
    assign s2_free   = !s2_valid_reg || s2_go;
    assign s1_go     = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s1_go;
    assign s0_go     = s0_valid_reg && s1_free;
    assign s0_free   = !s0_valid_reg || s0_go;
    assign in_stall  = !s0_free;
    assign in_take   = in_valid && s0_free;

    // Vertex classification and next polygon state.
    always_comb
    begin
        first_vtx    = !within_reg;
        differs      = (s0_x_reg != prior_x_reg) || (s0_y_reg != prior_y_reg);
        start_x_next = first_vtx ? s0_x_reg : start_x_reg;
        start_y_next = first_vtx ? s0_y_reg : start_y_reg;
        prior_x_next = (first_vtx || differs) ? s0_x_reg : prior_x_reg;
        prior_y_next = (first_vtx || differs) ? s0_y_reg : prior_y_reg;

        if (first_vtx)
        begin
            count_next = COUNT_ONE;
        end
        else if (differs && (count_reg < MAX_DISTINCT))
        begin
            count_next = count_reg + COUNT_ONE;
        end
        else
        begin
            count_next = count_reg;
        end

        // A last vertex equal to the first is not a distinct vertex.
        same_start = (prior_x_next == start_x_next) && (prior_y_next == start_y_next);
        count_fin  = (same_start && (count_next > COUNT_ONE)) ? count_next - COUNT_ONE
                                                              : count_next;

        within_next       = !s0_fin_reg;
        s1_ctl_next.first   = first_vtx;
        s1_ctl_next.edge_en = !first_vtx && differs;
        s1_ctl_next.fin     = s0_fin_reg;
        s1_ctl_next.degen   = (count_fin <= COUNT_TWO);
    end

    // Edge from the prior vertex to the current one.
    pot_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_cross (
        .ax        (prior_x_reg),
        .ay        (prior_y_reg),
        .bx        (s0_x_reg),
        .by        (s0_y_reg),
        .area_term (edge_cross)
    );

    // Closing edge from the updated prior vertex back to the first one.
    pot_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_close_cross (
        .ax        (prior_x_next),
        .ay        (prior_y_next),
        .bx        (start_x_next),
        .by        (start_y_next),
        .area_term (close_cross)
    );

    // Saturating accumulate of the edge term; a first vertex restarts at zero.
    always_comb
    begin
        sum_base = s1_ctl_reg.first ? SUM_ZERO : sum_reg;
        sum_wide = {sum_base[SUM_BITS-1], sum_base}
                 + {{(SUM_BITS+1-CROSS_BITS){s1_edge_reg[CROSS_BITS-1]}}, s1_edge_reg};
        if (!s1_ctl_reg.edge_en)
        begin
            sum_next = sum_base;
        end
        else if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
        begin
            sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_wide[SUM_BITS-1:0];
        end
    end

    // The closing term only decides the sign, which saturation would keep.
    assign total_wide = {sum_reg[SUM_BITS-1], sum_reg}
                      + {{(SUM_BITS+1-CROSS_BITS){s2_close_reg[CROSS_BITS-1]}}, s2_close_reg};

    // Output beat is loaded from a final vertex and held while stalled.
    always_comb
    begin
        if (s2_go && s2_fin_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= in_take || (s0_valid_reg && !s0_go);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_x_reg   <= x_coord;
            s0_y_reg   <= y_coord;
            s0_fin_reg <= final_vertex;
        end
    end

    // Polygon state advances as each vertex leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            within_reg  <= 1'b0;
            count_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prior_x_reg <= '0;
            prior_y_reg <= '0;
        end
        else if (s0_go)
        begin
            within_reg  <= within_next;
            count_reg   <= count_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            prior_x_reg <= prior_x_next;
            prior_y_reg <= prior_y_next;
        end
    end

    // Cross-product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_go || (s1_valid_reg && !s1_go);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_go)
        begin
            s1_ctl_reg   <= s1_ctl_next;
            s1_edge_reg  <= edge_cross;
            s1_close_reg <= close_cross;
        end
    end

    // Accumulator stage; the sum changes only when a vertex enters it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            s2_valid_reg <= s1_go || (s2_valid_reg && !s2_go);
            if (s1_go)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_fin_reg   <= s1_ctl_reg.fin;
            s2_degen_reg <= s1_ctl_reg.degen;
            s2_close_reg <= s1_close_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_fin_reg)
        begin
            clockwise_reg  <= s2_degen_reg || !total_wide[SUM_BITS];
            degenerate_reg <= s2_degen_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign clockwise  = clockwise_reg;
    assign degenerate = degenerate_reg;

`ifndef SYNTHESIS
    // A final vertex waiting for the output register keeps its sum.
    a_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_fin_reg && !out_ready) |=> (s2_valid_reg && $stable(sum_reg)))
        else $error("accumulator changed under a waiting final vertex");

    // A polygon closes only when a final vertex leaves the input register.
    a_close_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(within_reg) |-> $past(s0_go && s0_fin_reg))
        else $error("polygon closed without a final vertex");

    // Inside a polygon the distinct count lies between one and four.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        within_reg |-> ((count_reg != '0) && (count_reg <= MAX_DISTINCT)))
        else $error("distinct count out of range");

    // A degenerate polygon always reports clockwise.
    a_degen_cw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && degenerate_reg) |-> clockwise_reg)
        else $error("degenerate result without clockwise");

    // An empty input register never stalls the sender.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s0_valid_reg |-> !in_stall)
        else $error("input stalled while the input register is empty");
`endif

endmodule

FILE: verif/polygon_orientation_test_test.sv
// ----------------------------------------------------------------------------
// Polygon orientation test testbench
// Streams polygon vertices into the orientation block under random idling on
// both channels. A local shoelace predictor computes the expected orientation
// and degeneracy of every polygon, and the monitor checks each result beat
// against it. Directed polygons cover single vertices, repeated vertices, a
// closing vertex equal to the first, collinear points and extreme corners.
// ----------------------------------------------------------------------------
module polygon_orientation_test_test;
    import pot_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int RANDOM_BEATS = 1700;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 8;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [SUM_BITS-1:0] sum_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum int {FULL_RANGE, NEAR_ORIGIN, EXTREMES, MID_RANGE} coord_mode_t;

    // One pending vertex beat, or a marker that holds the sender until all
    // outstanding results have arrived.
    typedef struct {
        coord_t x;
        coord_t y;
        logic   fin;
        int     gap;
        logic   hold;
    } vertex_beat_t;

    typedef struct {
        logic cw;
        logic dg;
    } orientation_t;

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   in_valid     = 1'b0;
    logic   in_stall;
    coord_t x_coord      = '0;
    coord_t y_coord      = '0;
    logic   final_vertex = 1'b0;
    logic   out_valid;
    logic   out_stall    = 1'b0;
    logic   clockwise;
    logic   degenerate;

    vertex_beat_t pending_vertices[$];
    orientation_t orient_expect[$];
    vertex_beat_t next_beat;
    orientation_t want;

    // Predictor copy of the polygon state.
    sum_t                  shoelace_sum = SUM_ZERO;
    sum_t                  first_x      = '0;
    sum_t                  first_y      = '0;
    sum_t                  last_x       = '0;
    sum_t                  last_y       = '0;
    logic [COUNT_BITS-1:0] distinct_n   = '0;
    logic                  in_polygon   = 1'b0;

    int  send_wait      = 0;
    int  stall_left     = 0;
    bit  rx_calm        = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;

    polygon_orientation_test #(
        .COORD_BITS(COORD_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .final_vertex(final_vertex),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .clockwise(clockwise),
        .degenerate(degenerate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Signed add that clamps at the accumulator limits.
    function automatic sum_t clamp_add(input sum_t a, input sum_t b);
        logic signed [SUM_BITS:0] wide;
        wide = a + b;
        if (wide > SUM_MAX)
            return SUM_MAX;
        if (wide < SUM_MIN)
            return SUM_MIN;
        return sum_t'(wide);
    endfunction

    // Advance the polygon state by one accepted vertex; a final vertex
    // queues the orientation it produces.
    function automatic void shoelace_step(input coord_t x, input coord_t y, input logic fin);
        sum_t         vx;
        sum_t         vy;
        logic         degen;
        orientation_t res;
        vx = x;
        vy = y;
        if (!in_polygon)
        begin
            first_x      = vx;
            first_y      = vy;
            last_x       = vx;
            last_y       = vy;
            shoelace_sum = SUM_ZERO;
            distinct_n   = COUNT_ONE;
            in_polygon   = 1'b1;
        end
        else if (vx != last_x || vy != last_y)
        begin
            shoelace_sum = clamp_add(shoelace_sum, last_x * vy - vx * last_y);
            last_x = vx;
            last_y = vy;
            if (distinct_n < MAX_DISTINCT)
                distinct_n = distinct_n + COUNT_ONE;
        end
        if (fin)
        begin
            shoelace_sum = clamp_add(shoelace_sum, last_x * first_y - first_x * last_y);
            // A closing vertex on top of the first one is not a new corner.
            if (last_x == first_x && last_y == first_y && distinct_n > COUNT_ONE)
                distinct_n = distinct_n - COUNT_ONE;
            degen  = (distinct_n <= COUNT_TWO);
            res.cw = degen || (shoelace_sum >= SUM_ZERO);
            res.dg = degen;
            orient_expect.insert(orient_expect.size(), res);
            in_polygon = 1'b0;
        end
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic coord_t pick_coord(input coord_mode_t mode);
        case (mode)
            NEAR_ORIGIN: return coord_t'(int'($urandom_range(0, 8)) - 4);
            MID_RANGE:   return coord_t'(int'($urandom_range(0, 2000)) - 1000);
            EXTREMES:
            begin
                case ($urandom_range(0, 4))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return coord_t'(-1);
                    3:       return coord_t'(1);
                    default: return '0;
                endcase
            end
            default:     return coord_t'($urandom);
        endcase
    endfunction

    task automatic add_vertex(input coord_t x, input coord_t y, input logic fin, input int gap);
        vertex_beat_t b;
        b.x    = x;
        b.y    = y;
        b.fin  = fin;
        b.gap  = gap;
        b.hold = 1'b0;
        pending_vertices.insert(pending_vertices.size(), b);
    endtask

    task automatic add_pause();
        vertex_beat_t b;
        b.x    = '0;
        b.y    = '0;
        b.fin  = 1'b0;
        b.gap  = 0;
        b.hold = 1'b1;
        pending_vertices.insert(pending_vertices.size(), b);
    endtask

    // Sender: presents the next vertex once the current beat is taken, after
    // the idle cycles drawn for the previous one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                shoelace_step(x_coord, y_coord, final_vertex);
            if (!in_valid || !in_stall)
            begin
                if (send_wait > 0)
                begin
                    send_wait = send_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_vertices.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_vertices[0].hold)
                begin
                    in_valid <= 1'b0;
                    if (orient_expect.size() == 0)
                        next_beat = pending_vertices.pop_front();
                end
                else
                begin
                    next_beat = pending_vertices.pop_front();
                    x_coord      <= next_beat.x;
                    y_coord      <= next_beat.y;
                    final_vertex <= next_beat.fin;
                    in_valid     <= 1'b1;
                    send_wait    = next_beat.gap;
                end
            end
        end
    end

    // Receiver: checks each result beat and stalls at random, with calm
    // stretches that toggle now and then.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 255) == 0)
                rx_calm = !rx_calm;
            if (out_valid && !out_stall)
            begin
                if (orient_expect.size() == 0)
                begin
                    $error("unexpected result beat: clockwise=%0b degenerate=%0b",
                           clockwise, degenerate);
                    mismatch_count++;
                end
                else
                begin
                    want = orient_expect.pop_front();
                    if (clockwise !== want.cw)
                    begin
                        $error("clockwise: expected %0b, got %0b", want.cw, clockwise);
                        mismatch_count++;
                    end
                    if (degenerate !== want.dg)
                    begin
                        $error("degenerate: expected %0b, got %0b", want.dg, degenerate);
                        mismatch_count++;
                    end
                end
                stall_left = draw_wait(rx_calm);
            end
            else if (stall_left == 0 && $urandom_range(0, 15) == 0)
                stall_left = draw_wait(rx_calm);
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[polygon_orientation_test] ERROR");
            $finish;
        end
    end

    initial
    begin
        int          n_rand;
        int          len;
        bit          burst;
        coord_mode_t mode;
        coord_t      vx;
        coord_t      vy;
        coord_t      fx;
        coord_t      fy;

        // Single vertex that is also final, then a two-vertex polygon.
        add_vertex(COORD_MAX, COORD_MIN, 1'b1, $urandom_range(0, 11));
        add_vertex(coord_t'(0), coord_t'(0), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(5), coord_t'(5), 1'b1, $urandom_range(0, 11));
        // Triangle in both orientations.
        add_vertex(coord_t'(0), coord_t'(0), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(10), coord_t'(0), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(0), coord_t'(10), 1'b1, $urandom_range(0, 11));
        add_vertex(coord_t'(0), coord_t'(0), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(0), coord_t'(10), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(10), coord_t'(0), 1'b1, $urandom_range(0, 11));
        // Repeated vertices, including a repeated final one.
        add_vertex(coord_t'(1), coord_t'(1), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(1), coord_t'(1), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(4), coord_t'(1), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(1), coord_t'(5), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(1), coord_t'(5), 1'b1, $urandom_range(0, 11));
        // Closing vertex equal to the first: a triangle, then a degenerate pair.
        add_vertex(coord_t'(0), coord_t'(0), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(7), coord_t'(0), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(0), coord_t'(7), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(0), coord_t'(0), 1'b1, $urandom_range(0, 11));
        add_vertex(coord_t'(3), coord_t'(3), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(9), coord_t'(9), 1'b0, $urandom_range(0, 11));
        add_vertex(coord_t'(3), coord_t'(3), 1'b1, $urandom_range(0, 11));
        // Collinear points give a zero area.
        add_vertex(coord_t'(-2), coord_t'(-2), 1'b0, 0);
        add_vertex(coord_t'(1), coord_t'(1), 1'b0, 0);
        add_vertex(coord_t'(2), coord_t'(2), 1'b1, 0);
        // Full-range square.
        add_vertex(COORD_MIN, COORD_MIN, 1'b0, 0);
        add_vertex(COORD_MAX, COORD_MIN, 1'b0, 0);
        add_vertex(COORD_MAX, COORD_MAX, 1'b0, 0);
        add_vertex(COORD_MIN, COORD_MAX, 1'b1, $urandom_range(0, 11));
        add_pause();

        // Random polygons: mostly short, some long, with repeats and closures.
        n_rand = 0;
        while (n_rand < RANDOM_BEATS)
        begin
            len   = ($urandom_range(0, 7) == 0) ? int'($urandom_range(7, 20))
                                                : int'($urandom_range(1, 6));
            mode  = coord_mode_t'($urandom_range(0, 3));
            burst = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len; k++)
            begin
                if (k > 0 && $urandom_range(0, 5) == 0)
                begin
                    // Keep the previous vertex: a repeat.
                end
                else if (k > 0 && k == len - 1 && $urandom_range(0, 3) == 0)
                begin
                    vx = fx;
                    vy = fy;
                end
                else
                begin
                    vx = pick_coord(mode);
                    vy = pick_coord(mode);
                end
                if (k == 0)
                begin
                    fx = vx;
                    fy = vy;
                end
                add_vertex(vx, vy, k == len - 1, burst ? 0 : draw_wait(1'b0));
            end
            n_rand += len;
            if ($urandom_range(0, 39) == 0)
                add_pause();
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_vertices.size() != 0 || in_valid || orient_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (orient_expect.size() != 0)
        begin
            $error("%0d expected results never arrived", orient_expect.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[polygon_orientation_test] OK");
        else
            $display("[polygon_orientation_test] ERROR");
        $finish;
    end

endmodule

FILE: polygon_orientation_test.f
src/pot_pkg.sv
src/pot_cross.sv
src/polygon_orientation_test.sv
verif/polygon_orientation_test_test.sv
